[rtl/stt_pkg.sv]
package stt_pkg;

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOI  = 2'd2;

    localparam logic [4:0] K_BANGEQ = 5'd11;
    localparam logic [4:0] K_EQEQ   = 5'd12;
    localparam logic [4:0] K_EQ     = 5'd13;
    localparam logic [4:0] K_KW0    = 5'd14;
    localparam logic [4:0] K_IDENT  = 5'd21;
    localparam logic [4:0] K_NUMBER = 5'd22;
    localparam logic [4:0] K_EOF    = 5'd23;
    localparam logic [4:0] K_ERROR  = 5'd24;

    localparam int NUM_PUNCT = 11;
    localparam int NUM_KW    = 7;

    // punctuator kind is its index here
    localparam logic [7:0] PUNCT_CHAR [NUM_PUNCT] = '{
        8'h28, 8'h7b, 8'h29, 8'h7d, 8'h3b, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3e, 8'h3c
    };

    // keyword text packed right-aligned, eight bits a character
    localparam logic [39:0] KW_TEXT [NUM_KW] = '{
        40'h0000696e74,
        40'h00626f6f6c,
        40'h7072696e74,
        40'h0000006966,
        40'h00656c7365,
        40'h006c6f6f70,
        40'h627265616b
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd4, 3'd5
    };

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_BANG = 3'd3,
        MODE_EQ   = 3'd4,
        MODE_SKIP = 3'd5
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [11:0] col;
        logic [12:0] len;
        logic [31:0] value;
        logic        last;
    } token_t;

    // up to two tokens from one word, pre comes first
    typedef struct packed {
        logic   pre_v;
        token_t pre;
        logic   post_v;
        token_t post;
    } scan_res_t;

endpackage

[rtl/source_text_tokenizer.sv]
// channel | direction | handshake                  | payload
// char    | in        | char_valid / char_ready    | operation, char_byte
// token   | out       | token_valid / token_ready  | token_kind, line_number, start_column,
//         |           |                            | token_length, number_value, last_of_run
//
// a word is taken every cycle while char_ready is high; its tokens go into the queue
// when it leaves the input register, and a word giving two tokens writes both at once
// a four-entry token queue sits after the scanner; char_ready drops while the
// input register is full and the queue holds more than two tokens
// rst_n clears the line and column counters, the scan state and the queue at once
module source_text_tokenizer #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_LINES       = 65536,
    parameter int NUMBER_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] line_number,
    output logic [11:0] start_column,
    output logic [12:0] token_length,
    output logic [31:0] number_value,
    output logic        last_of_run
);

    logic       in_v_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic       fire;
    logic       room;
    logic       pop;
    stt_pkg::scan_res_t res;
    stt_pkg::token_t    head;

    assign fire       = in_v_reg && room;
    assign char_ready = !in_v_reg || fire;
    assign pop        = token_valid && token_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            in_v_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            op_reg   <= operation;
            byte_reg <= char_byte;
        end
    end

    stt_scan #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .MAX_LINES       (MAX_LINES),
        .NUMBER_BITS     (NUMBER_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .operation (op_reg),
        .char_byte (byte_reg),
        .res       (res)
    );

    stt_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res       (res),
        .pop       (pop),
        .room      (room),
        .not_empty (token_valid),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign line_number  = head.line;
    assign start_column = head.col;
    assign token_length = head.len;
    assign number_value = head.value;
    assign last_of_run  = head.last;

`ifndef SYNTHESIS
    a_fire_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.pre_v || res.post_v) |=> token_valid)
        else $error("scanned token missing from output");
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_v_reg |-> char_ready)
        else $error("input stalled with empty input register");
`endif

endmodule

[rtl/stt_scan.sv]
module stt_scan #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_LINES       = 65536,
    parameter int NUMBER_BITS     = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          operation,
    input  logic [7:0]          char_byte,
    output stt_pkg::scan_res_t  res
);

    localparam int COL_W  = $clog2(MAX_LINE_LENGTH);
    localparam int LEN_W  = $clog2(MAX_LINE_LENGTH + 1);
    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int NB     = NUMBER_BITS;

    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(MAX_LINE_LENGTH - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LINE_LENGTH);
    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINES - 1);
    localparam logic [NB-1:0]     NUM_MAX  = '1;

    stt_pkg::scan_mode_t mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [39:0]       kb_reg, kb_next;
    logic [NB-1:0]     acc_reg, acc_next;

    logic              is_letter, is_digit, is_space, is_word;
    logic              p_hit;
    logic [4:0]        p_kind;
    logic [4:0]        wk;
    logic              fl_v;
    logic [4:0]        fl_kind;
    logic [LEN_W-1:0]  fl_len;
    logic [NB-1:0]     fl_val;
    logic [NB-1:0]     acc_grown;

    logic              pre_v, post_v, rescan;
    logic [4:0]        pre_kind, post_kind;
    logic [LEN_W-1:0]  pre_len, post_len;
    logic [NB-1:0]     pre_val;
    logic [COL_W-1:0]  post_col;
    logic [LINE_W-1:0] post_line;

    function automatic logic [NB-1:0] acc_add(input logic [NB-1:0] a, input logic [7:0] ch);
        logic [NB+3:0] t;
        t = ((NB+4)'(a) << 3) + ((NB+4)'(a) << 1) + (NB+4)'(ch - stt_pkg::CH_ZERO);
        if (t > (NB+4)'(NUM_MAX))
        begin
            return NUM_MAX;
        end
        return t[NB-1:0];
    endfunction

    function automatic stt_pkg::token_t to_tok(
        input logic [4:0]        kind,
        input logic [LINE_W-1:0] line,
        input logic [COL_W-1:0]  col,
        input logic [LEN_W-1:0]  len,
        input logic [NB-1:0]     val,
        input logic              last
    );
        stt_pkg::token_t t;
        logic [63:0] line_w, col_w, len_w, val_w;
        line_w  = 64'(line);
        col_w   = 64'(col);
        len_w   = 64'(len);
        val_w   = 64'(val);
        t.kind  = kind;
        t.line  = line_w[15:0];
        t.col   = col_w[11:0];
        t.len   = len_w[12:0];
        t.value = val_w[31:0];
        t.last  = last;
        return t;
    endfunction

    // character classes
    always_comb
    begin
        is_letter = (char_byte >= 8'h61 && char_byte <= 8'h7a)
                 || (char_byte >= 8'h41 && char_byte <= 8'h5a);
        is_digit  = char_byte >= 8'h30 && char_byte <= 8'h39;
        is_space  = char_byte == 8'h20 || (char_byte >= 8'h09 && char_byte <= 8'h0d);
        is_word   = is_letter || is_digit || char_byte == stt_pkg::CH_UNDER;
        p_hit     = 1'b0;
        p_kind    = '0;
        for (int k = 0; k < stt_pkg::NUM_PUNCT; k++)
        begin
            if (char_byte == stt_pkg::PUNCT_CHAR[k])
            begin
                p_hit  = 1'b1;
                p_kind = 5'(k);
            end
        end
    end

    // keyword match on the buffered word
    always_comb
    begin
        wk = stt_pkg::K_IDENT;
        for (int k = stt_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (len_reg == LEN_W'(stt_pkg::KW_LEN[k]) && kb_reg == stt_pkg::KW_TEXT[k])
            begin
                wk = stt_pkg::K_KW0 + 5'(k);
            end
        end
    end

    // pending token at a boundary
    always_comb
    begin
        fl_v    = 1'b0;
        fl_kind = '0;
        fl_len  = LEN_W'(1);
        fl_val  = '0;
        unique case (mode_reg)
            stt_pkg::MODE_WORD:
            begin
                fl_v    = 1'b1;
                fl_kind = wk;
                fl_len  = len_reg;
            end
            stt_pkg::MODE_NUM:
            begin
                fl_v    = 1'b1;
                fl_kind = stt_pkg::K_NUMBER;
                fl_len  = len_reg;
                fl_val  = acc_reg;
            end
            stt_pkg::MODE_BANG:
            begin
                fl_v    = 1'b1;
                fl_kind = stt_pkg::K_ERROR;
            end
            stt_pkg::MODE_EQ:
            begin
                fl_v    = 1'b1;
                fl_kind = stt_pkg::K_EQ;
            end
            default:
            begin
                fl_v = 1'b0;
            end
        endcase
    end

    assign acc_grown = acc_add(acc_reg, char_byte);

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kb_next    = kb_reg;
        acc_next   = acc_reg;
        pre_v      = 1'b0;
        pre_kind   = '0;
        pre_len    = '0;
        pre_val    = '0;
        post_v     = 1'b0;
        post_kind  = '0;
        post_len   = LEN_W'(1);
        post_col   = col_reg;
        post_line  = line_reg;
        rescan     = 1'b0;
        if (fire)
        begin
            unique case (operation)
                stt_pkg::OP_CHAR:
                begin
                    unique case (mode_reg)
                        stt_pkg::MODE_WORD:
                        begin
                            if (is_word)
                            begin
                                if (len_reg < LEN_W'(5))
                                begin
                                    kb_next = {kb_reg[31:0], char_byte};
                                end
                                if (len_reg < LEN_MAX)
                                begin
                                    len_next = len_reg + LEN_W'(1);
                                end
                            end
                            else
                            begin
                                pre_v     = fl_v;
                                pre_kind  = fl_kind;
                                pre_len   = fl_len;
                                mode_next = stt_pkg::MODE_IDLE;
                                rescan    = 1'b1;
                            end
                        end
                        stt_pkg::MODE_NUM:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_grown;
                                if (len_reg < LEN_MAX)
                                begin
                                    len_next = len_reg + LEN_W'(1);
                                end
                            end
                            else
                            begin
                                pre_v     = fl_v;
                                pre_kind  = fl_kind;
                                pre_len   = fl_len;
                                pre_val   = fl_val;
                                mode_next = stt_pkg::MODE_IDLE;
                                rescan    = 1'b1;
                            end
                        end
                        stt_pkg::MODE_BANG:
                        begin
                            pre_v = 1'b1;
                            if (char_byte == stt_pkg::CH_EQ)
                            begin
                                pre_kind  = stt_pkg::K_BANGEQ;
                                pre_len   = LEN_W'(2);
                                mode_next = stt_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                pre_kind  = stt_pkg::K_ERROR;
                                pre_len   = LEN_W'(1);
                                mode_next = stt_pkg::MODE_SKIP;
                            end
                        end
                        stt_pkg::MODE_EQ:
                        begin
                            pre_v     = 1'b1;
                            mode_next = stt_pkg::MODE_IDLE;
                            if (char_byte == stt_pkg::CH_EQ)
                            begin
                                pre_kind = stt_pkg::K_EQEQ;
                                pre_len  = LEN_W'(2);
                            end
                            else
                            begin
                                pre_kind = stt_pkg::K_EQ;
                                pre_len  = LEN_W'(1);
                                rescan   = 1'b1;
                            end
                        end
                        stt_pkg::MODE_SKIP:
                        begin
                            rescan = 1'b0;
                        end
                        default:
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                            rescan    = 1'b1;
                        end
                    endcase
                    if (rescan && !is_space)
                    begin
                        if (p_hit)
                        begin
                            post_v    = 1'b1;
                            post_kind = p_kind;
                        end
                        else if (char_byte == stt_pkg::CH_BANG || char_byte == stt_pkg::CH_EQ
                                 || is_letter || is_digit)
                        begin
                            start_next = col_reg;
                            len_next   = LEN_W'(1);
                            kb_next    = '0;
                            acc_next   = '0;
                            if (char_byte == stt_pkg::CH_BANG)
                            begin
                                mode_next = stt_pkg::MODE_BANG;
                            end
                            else if (char_byte == stt_pkg::CH_EQ)
                            begin
                                mode_next = stt_pkg::MODE_EQ;
                            end
                            else if (is_letter)
                            begin
                                mode_next = stt_pkg::MODE_WORD;
                                kb_next   = 40'(char_byte);
                            end
                            else
                            begin
                                mode_next = stt_pkg::MODE_NUM;
                                acc_next  = NB'(char_byte - stt_pkg::CH_ZERO);
                            end
                        end
                        else
                        begin
                            post_v    = 1'b1;
                            post_kind = stt_pkg::K_ERROR;
                            mode_next = stt_pkg::MODE_SKIP;
                        end
                    end
                    if (col_reg < COL_MAX)
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                stt_pkg::OP_EOL:
                begin
                    pre_v     = fl_v;
                    pre_kind  = fl_kind;
                    pre_len   = fl_len;
                    pre_val   = fl_val;
                    mode_next = stt_pkg::MODE_IDLE;
                    if (line_reg < LINE_MAX)
                    begin
                        line_next = line_reg + LINE_W'(1);
                    end
                    col_next = '0;
                end
                stt_pkg::OP_EOI:
                begin
                    pre_v     = fl_v;
                    pre_kind  = fl_kind;
                    pre_len   = fl_len;
                    pre_val   = fl_val;
                    post_v    = 1'b1;
                    post_kind = stt_pkg::K_EOF;
                    post_col  = '0;
                    post_len  = '0;
                    if (col_reg != '0 && line_reg < LINE_MAX)
                    begin
                        post_line = line_reg + LINE_W'(1);
                    end
                    mode_next  = stt_pkg::MODE_IDLE;
                    line_next  = '0;
                    col_next   = '0;
                    start_next = '0;
                    len_next   = '0;
                    kb_next    = '0;
                    acc_next   = '0;
                end
                default:
                begin
                    rescan = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.pre_v  = pre_v;
        res.pre    = to_tok(pre_kind, line_reg, start_reg, pre_len, pre_val, !post_v);
        res.post_v = post_v;
        res.post   = to_tok(post_kind, post_line, post_col, post_len, '0, 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            line_reg  <= '0;
            col_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            kb_reg    <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kb_reg    <= kb_next;
            acc_reg   <= acc_next;
        end
    end

`ifndef SYNTHESIS
    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && operation == stt_pkg::OP_EOI
        |=> line_reg == '0 && col_reg == '0 && mode_reg == stt_pkg::MODE_IDLE)
        else $error("end of input left scanner state behind");
`endif

endmodule

[rtl/stt_tok_fifo.sv]
module stt_tok_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stt_pkg::scan_res_t res,
    input  logic               pop,
    output logic               room,
    output logic               not_empty,
    output stt_pkg::token_t    head
);

    localparam int DEPTH = 4;

    stt_pkg::token_t mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    stt_pkg::token_t first;

    always_comb
    begin
        n_push      = push ? (2'(res.pre_v) + 2'(res.post_v)) : 2'd0;
        first       = res.pre_v ? res.pre : res.post;
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(n_push) - 3'(pop);
    end

    assign room      = count_reg <= 3'd2;
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= first;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= res.post;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("token queue overfilled");
`endif

endmodule

[bench/token_checker.sv]
`timescale 1ns / 1ps
module token_checker #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_LINES       = 65536,
    parameter int NUMBER_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_byte,
    input  logic        token_valid,
    input  logic        token_ready,
    input  logic [4:0]  token_kind,
    input  logic [15:0] line_number,
    input  logic [11:0] start_column,
    input  logic [12:0] token_length,
    input  logic [31:0] number_value,
    input  logic        last_of_run,
    output int          fail_count,
    output int          pending
);

    localparam longint unsigned NUM_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

    int                  line_cnt = 0;
    int                  col_cnt = 0;
    stt_pkg::scan_mode_t mode = stt_pkg::MODE_IDLE;
    int                  tok_begin = 0;
    int                  tok_len = 0;
    logic [39:0]         kw_buf = '0;
    longint unsigned     num_acc = 0;

    stt_pkg::token_t     tokens_due [$];
    stt_pkg::token_t     held;
    bit                  held_v;
    stt_pkg::token_t     want;
    int                  errors = 0;
    int                  due_count = 0;
    int                  tokens_seen = 0;

    assign fail_count = errors;
    assign pending = due_count;

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic bit is_space(input logic [7:0] ch);
        return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at token %0d: %s", tokens_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned exp_val);
        if (got != exp_val)
        begin
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, exp_val));
        end
    endtask

    // the previous token goes out first, the final one gets its last flag later
    task automatic emit_token(input logic [4:0] kind, input int line, input int col,
                              input int len, input logic [31:0] value);
        if (held_v)
        begin
            tokens_due = {tokens_due, held};
        end
        held.kind  = kind;
        held.line  = line[15:0];
        held.col   = col[11:0];
        held.len   = len[12:0];
        held.value = value;
        held.last  = 1'b0;
        held_v     = 1'b1;
    endtask

    task automatic clear_state();
        line_cnt  = 0;
        col_cnt   = 0;
        mode      = stt_pkg::MODE_IDLE;
        tok_begin = 0;
        tok_len   = 0;
        kw_buf    = '0;
        num_acc   = 0;
    endtask

    task automatic open_token(input stt_pkg::scan_mode_t new_mode, input int col);
        mode      = new_mode;
        tok_begin = col;
        tok_len   = 1;
        kw_buf    = '0;
        num_acc   = 0;
    endtask

    task automatic add_digit(input logic [7:0] ch);
        longint unsigned d;
        d = longint'(ch - stt_pkg::CH_ZERO);
        if (num_acc > (NUM_MAX - d) / 10)
        begin
            num_acc = NUM_MAX;
        end
        else
        begin
            num_acc = num_acc * 10 + d;
        end
    endtask

    task automatic grow_len();
        if (tok_len < MAX_LINE_LENGTH)
        begin
            tok_len++;
        end
    endtask

    // ends a pending word, number, bang or equals at a boundary
    task automatic close_token();
        logic [4:0] kind;
        case (mode)
            stt_pkg::MODE_WORD:
            begin
                kind = stt_pkg::K_IDENT;
                for (int k = 0; k < stt_pkg::NUM_KW; k++)
                begin
                    if (int'(stt_pkg::KW_LEN[k]) == tok_len && stt_pkg::KW_TEXT[k] == kw_buf)
                    begin
                        kind = stt_pkg::K_KW0 + 5'(k);
                    end
                end
                emit_token(kind, line_cnt, tok_begin, tok_len, '0);
            end
            stt_pkg::MODE_NUM:
            begin
                emit_token(stt_pkg::K_NUMBER, line_cnt, tok_begin, tok_len, num_acc[31:0]);
            end
            stt_pkg::MODE_BANG:
            begin
                emit_token(stt_pkg::K_ERROR, line_cnt, tok_begin, 1, '0);
            end
            stt_pkg::MODE_EQ:
            begin
                emit_token(stt_pkg::K_EQ, line_cnt, tok_begin, 1, '0);
            end
            default:
            begin
            end
        endcase
        mode = stt_pkg::MODE_IDLE;
    endtask

    task automatic tokenise(input logic [1:0] op, input logic [7:0] ch);
        int col;
        bit rescan;
        bit found;
        int lines;
        held_v = 1'b0;
        col = col_cnt;
        if (op == stt_pkg::OP_CHAR)
        begin
            rescan = 1'b1;
            case (mode)
                stt_pkg::MODE_WORD:
                begin
                    if (is_letter(ch) || is_digit(ch) || ch == stt_pkg::CH_UNDER)
                    begin
                        if (tok_len < 5)
                        begin
                            kw_buf = {kw_buf[31:0], ch};
                        end
                        grow_len();
                        rescan = 1'b0;
                    end
                    else
                    begin
                        close_token();
                    end
                end
                stt_pkg::MODE_NUM:
                begin
                    if (is_digit(ch))
                    begin
                        add_digit(ch);
                        grow_len();
                        rescan = 1'b0;
                    end
                    else
                    begin
                        close_token();
                    end
                end
                stt_pkg::MODE_BANG:
                begin
                    if (ch == stt_pkg::CH_EQ)
                    begin
                        emit_token(stt_pkg::K_BANGEQ, line_cnt, tok_begin, 2, '0);
                        mode = stt_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        emit_token(stt_pkg::K_ERROR, line_cnt, tok_begin, 1, '0);
                        mode = stt_pkg::MODE_SKIP;
                    end
                    rescan = 1'b0;
                end
                stt_pkg::MODE_EQ:
                begin
                    if (ch == stt_pkg::CH_EQ)
                    begin
                        emit_token(stt_pkg::K_EQEQ, line_cnt, tok_begin, 2, '0);
                        mode = stt_pkg::MODE_IDLE;
                        rescan = 1'b0;
                    end
                    else
                    begin
                        close_token();
                    end
                end
                stt_pkg::MODE_SKIP:
                begin
                    rescan = 1'b0;
                end
                default:
                begin
                    mode = stt_pkg::MODE_IDLE;
                end
            endcase
            if (rescan && !is_space(ch))
            begin
                found = 1'b0;
                for (int k = 0; k < stt_pkg::NUM_PUNCT; k++)
                begin
                    if (stt_pkg::PUNCT_CHAR[k] == ch)
                    begin
                        emit_token(5'(k), line_cnt, col, 1, '0);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (ch == stt_pkg::CH_BANG)
                    begin
                        open_token(stt_pkg::MODE_BANG, col);
                    end
                    else if (ch == stt_pkg::CH_EQ)
                    begin
                        open_token(stt_pkg::MODE_EQ, col);
                    end
                    else if (is_letter(ch))
                    begin
                        open_token(stt_pkg::MODE_WORD, col);
                        kw_buf = {32'd0, ch};
                    end
                    else if (is_digit(ch))
                    begin
                        open_token(stt_pkg::MODE_NUM, col);
                        add_digit(ch);
                    end
                    else
                    begin
                        emit_token(stt_pkg::K_ERROR, line_cnt, col, 1, '0);
                        mode = stt_pkg::MODE_SKIP;
                    end
                end
            end
            if (col_cnt < MAX_LINE_LENGTH - 1)
            begin
                col_cnt++;
            end
        end
        else if (op == stt_pkg::OP_EOL)
        begin
            close_token();
            if (line_cnt < MAX_LINES - 1)
            begin
                line_cnt++;
            end
            col_cnt = 0;
        end
        else if (op == stt_pkg::OP_EOI)
        begin
            lines = line_cnt;
            close_token();
            // an unterminated last line still counts
            if (col_cnt > 0 && lines < MAX_LINES - 1)
            begin
                lines++;
            end
            emit_token(stt_pkg::K_EOF, lines, 0, 0, '0);
            clear_state();
        end
        if (held_v)
        begin
            held.last = 1'b1;
            tokens_due = {tokens_due, held};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            tokens_due.delete();
            due_count = 0;
        end
        else
        begin
            if (token_valid && token_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    report_mismatch("token arrived with none expected");
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", 64'(token_kind), 64'(want.kind));
                    check_field("line_number", 64'(line_number), 64'(want.line));
                    check_field("start_column", 64'(start_column), 64'(want.col));
                    check_field("token_length", 64'(token_length), 64'(want.len));
                    check_field("number_value", 64'(number_value), 64'(want.value));
                    check_field("last_of_run", 64'(last_of_run), 64'(want.last));
                end
                tokens_seen++;
            end
            if (char_valid && char_ready)
            begin
                tokenise(operation, char_byte);
            end
            due_count = tokens_due.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    localparam int LINE_LEN       = 4096;
    localparam int LINE_COUNT     = 65536;
    localparam int NUM_BITS       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 380;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    logic [1:0]  operation;
    logic [7:0]  char_byte;
    logic        token_valid;
    logic        token_ready;
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [11:0] start_column;
    logic [12:0] token_length;
    logic [31:0] number_value;
    logic        last_of_run;
    int          fail_count;
    int          pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_sent = 0;

    source_text_tokenizer #(
        .MAX_LINE_LENGTH(LINE_LEN),
        .MAX_LINES(LINE_COUNT),
        .NUMBER_BITS(NUM_BITS)
    ) dut (.*);

    token_checker #(
        .MAX_LINE_LENGTH(LINE_LEN),
        .MAX_LINES(LINE_COUNT),
        .NUMBER_BITS(NUM_BITS)
    ) token_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // token side: random stalls, or a long hold-off when asked
    initial
    begin
        token_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                token_ready <= 1'b0;
            end
            else
            begin
                token_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (token_valid && token_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] ch);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        operation  <= op;
        char_byte  <= ch;
        @(posedge clk);
        while (!char_ready)
        begin
            @(posedge clk);
        end
        if (op != OP_UNUSED)
        begin
            words_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send(stt_pkg::OP_CHAR, s[i]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        char_valid <= 1'b0;
        wait (pending == 0);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
        begin
            return 8'("a") + 8'($urandom_range(25));
        end
        return 8'("A") + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            return rand_letter();
        end
        else if (pick < 9)
        begin
            return stt_pkg::CH_ZERO + 8'($urandom_range(9));
        end
        return stt_pkg::CH_UNDER;
    endfunction

    task automatic send_lexeme();
        int pick;
        int k;
        int n;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            send(stt_pkg::OP_CHAR, stt_pkg::PUNCT_CHAR[$urandom_range(stt_pkg::NUM_PUNCT - 1)]);
        end
        else if (pick < 15)
        begin
            send_text("!=");
        end
        else if (pick < 20)
        begin
            send_text("==");
        end
        else if (pick < 25)
        begin
            send(stt_pkg::OP_CHAR, stt_pkg::CH_EQ);
        end
        else if (pick < 40)
        begin
            k = $urandom_range(stt_pkg::NUM_KW - 1);
            n = int'(stt_pkg::KW_LEN[k]);
            for (int i = n - 1; i >= 0; i--)
            begin
                send(stt_pkg::OP_CHAR, stt_pkg::KW_TEXT[k][8 * i +: 8]);
            end
            // keyword prefix of a longer word
            if ($urandom_range(3) == 0)
            begin
                send(stt_pkg::OP_CHAR, rand_word_char());
            end
        end
        else if (pick < 55)
        begin
            send(stt_pkg::OP_CHAR, rand_letter());
            n = $urandom_range(7);
            repeat (n) send(stt_pkg::OP_CHAR, rand_word_char());
        end
        else if (pick < 68)
        begin
            n = $urandom_range(14, 1);
            repeat (n) send(stt_pkg::OP_CHAR, stt_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
        else if (pick < 78)
        begin
            if ($urandom_range(4) != 0)
            begin
                send(stt_pkg::OP_CHAR, " ");
            end
            else
            begin
                send(stt_pkg::OP_CHAR, 8'($urandom_range(13, 9)));
            end
        end
        else if (pick < 86)
        begin
            send(stt_pkg::OP_EOL, 8'($urandom_range(255)));
        end
        else if (pick < 88)
        begin
            send(stt_pkg::OP_EOI, 8'($urandom_range(255)));
        end
        else if (pick < 92)
        begin
            send(stt_pkg::OP_CHAR, stt_pkg::CH_BANG);
        end
        else if (pick < 96)
        begin
            send(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
        else if (pick < 98)
        begin
            send(stt_pkg::OP_CHAR, stt_pkg::CH_UNDER);
        end
        else
        begin
            send(stt_pkg::OP_CHAR, 8'($urandom_range(255, 128)));
        end
    endtask

    task automatic random_run(input int count);
        int mark;
        mark = words_sent;
        while (words_sent - mark < count)
        begin
            send_lexeme();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        operation  = stt_pkg::OP_CHAR;
        char_byte  = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every punctuator, pairs, lone marks, bad bytes, keyword ended by end of input
        send_text("({)};+-*/><");
        send(stt_pkg::OP_EOL, 8'hff);
        send_text("!==x");
        send(stt_pkg::OP_EOL, 8'h00);
        send_text("9!");
        send(stt_pkg::OP_EOL, 8'h00);
        send_text("!a_");
        send(stt_pkg::OP_EOL, 8'h00);
        send(stt_pkg::OP_CHAR, 8'hff);
        send(stt_pkg::OP_EOL, 8'h00);
        send(OP_UNUSED, 8'hff);
        send_text("int");
        send(stt_pkg::OP_EOI, 8'h00);
        drain();

        // token side held off while characters keep coming
        hold_ask++;
        repeat (60) send(stt_pkg::OP_CHAR,
                         stt_pkg::PUNCT_CHAR[$urandom_range(stt_pkg::NUM_PUNCT - 1)]);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            random_run(PHASE_WORDS);
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[source_text_tokenizer.f]
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_tok_fifo.sv
rtl/source_text_tokenizer.sv
bench/token_checker.sv
bench/testbench.sv
